FILE: hdl/pts_pkg.sv
// Shared types, constants and a highest-set-bit function for the priority tick scheduler.
// No dependencies.
package pts_pkg;

    localparam int BANK_SIZE = 32;
    localparam int PRIO_W    = 5;
    localparam int ADDR_W    = PRIO_W + 1;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_TICK   = 2'd0;
    localparam t_kind KIND_DELAY  = 2'd1;
    localparam t_kind KIND_CREATE = 2'd2;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] delay_ticks;
        logic [4:0]  task_priority;
    } t_item;

    typedef struct packed {
        logic [4:0]  run_priority;
        logic        run_valid;
        logic [31:0] ready_set;
        logic [31:0] delayed_set;
        logic [31:0] tick_now;
    } t_result;

    function automatic logic [PRIO_W-1:0] highest_set(input logic [BANK_SIZE-1:0] m);
        logic [PRIO_W-1:0] p;
        p = '0;
        for (int i = 0; i < BANK_SIZE; i++) begin
            if (m[i]) begin
                p = PRIO_W'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: hdl/priority_tick_scheduler.sv
// Priority tick scheduler: ready/delayed masks, tick count, two wake-time banks. Uses pts_pkg.
// A tick walks S_SCAN, one wake-memory entry per cycle, then S_DRAIN and S_FIN before o_done;
// delay, create and other kinds go from S_IDLE straight to S_FIN.
// No new item is taken until the current one is done; the next start is taken in the o_done cycle.
// The receiver cannot stall; each result shows for one cycle under o_done.
// Sync active-low reset clears masks, tick count, bank select and all wake valid bits at once.
module priority_tick_scheduler #(
    parameter int NUM_PRIORITIES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  pts_pkg::t_item  i_item,
    output logic            busy,
    output logic            o_done,
    output pts_pkg::t_result o_result
);
    import pts_pkg::*;

    localparam logic [BANK_SIZE-1:0] P_MASK = {BANK_SIZE{1'b1}} >> (BANK_SIZE - NUM_PRIORITIES);
    localparam logic [PRIO_W-1:0]    LAST_IDX = PRIO_W'(NUM_PRIORITIES - 1);
    localparam int                   DEPTH = 2 * BANK_SIZE;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                r_state,   n_state;
    logic [31:0]           r_tick,    n_tick;
    logic                  r_bank,    n_bank;
    logic [BANK_SIZE-1:0]  r_ready,   n_ready;
    logic [BANK_SIZE-1:0]  r_delayed, n_delayed;
    logic [PRIO_W-1:0]     r_cur,     n_cur;
    logic [DEPTH-1:0]      r_wvld,    n_wvld;
    logic [PRIO_W-1:0]     r_idx,     n_idx;
    logic                  r_chk,     n_chk;
    logic [PRIO_W-1:0]     r_chk_idx, n_chk_idx;
    logic                  r_resched, n_resched;
    logic                  r_done,    n_done;
    t_result               r_result,  n_result;

    logic [31:0]           mem [DEPTH];
    logic [31:0]           r_rd_data;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [31:0]           mem_wdata;

    logic [ADDR_W-1:0]     chk_addr;
    logic                  hit;
    logic [32:0]           wake_sum;

    assign rd_addr  = {r_bank, r_idx};
    assign chk_addr = {r_bank, r_chk_idx};
    assign hit      = r_chk && r_wvld[chk_addr] && (r_rd_data != 32'd0)
                      && (r_tick >= r_rd_data);
    assign wake_sum = {1'b0, r_tick} + {17'd0, i_item.delay_ticks};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_tick    = r_tick;
        n_bank    = r_bank;
        n_ready   = r_ready;
        n_delayed = r_delayed;
        n_cur     = r_cur;
        n_wvld    = r_wvld;
        n_idx     = r_idx;
        n_chk     = 1'b0;
        n_chk_idx = r_chk_idx;
        n_resched = r_resched;
        n_done    = 1'b0;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;

        if (hit) begin
            n_wvld[chk_addr]     = 1'b0;
            n_delayed[r_chk_idx] = 1'b0;
            n_ready[r_chk_idx]   = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.kind)
                        KIND_TICK: begin
                            n_tick = r_tick + 32'd1;
                            if (n_tick == 32'd0) begin
                                n_bank = ~r_bank;
                            end
                            n_idx     = '0;
                            n_resched = 1'b1;
                            n_state   = S_SCAN;
                        end
                        KIND_DELAY: begin
                            mem_we    = 1'b1;
                            mem_waddr = {wake_sum[32] ? ~r_bank : r_bank, r_cur};
                            mem_wdata = wake_sum[31:0];
                            n_wvld[mem_waddr] = 1'b1;
                            n_delayed[r_cur]  = 1'b1;
                            n_ready[r_cur]    = 1'b0;
                            n_resched = 1'b1;
                            n_state   = S_FIN;
                        end
                        KIND_CREATE: begin
                            if ({1'b0, i_item.task_priority} < (PRIO_W + 1)'(NUM_PRIORITIES)) begin
                                n_cur = i_item.task_priority;
                                n_ready[i_item.task_priority] = 1'b1;
                            end
                            n_resched = 1'b0;
                            n_state   = S_FIN;
                        end
                        default: begin
                            n_resched = 1'b0;
                            n_state   = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_chk     = 1'b1;
                n_chk_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + PRIO_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_ready   = r_ready & P_MASK;
                n_delayed = r_delayed & P_MASK;
                if (r_resched && (n_ready != '0)) begin
                    n_cur = highest_set(n_ready);
                end
                n_done                = 1'b1;
                n_result.run_priority = n_cur;
                n_result.run_valid    = (n_ready != '0);
                n_result.ready_set    = n_ready;
                n_result.delayed_set  = n_delayed;
                n_result.tick_now     = r_tick;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_bank    <= 1'b0;
            r_ready   <= '0;
            r_delayed <= '0;
            r_cur     <= '0;
            r_wvld    <= '0;
            r_idx     <= '0;
            r_chk     <= 1'b0;
            r_chk_idx <= '0;
            r_resched <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tick    <= n_tick;
            r_bank    <= n_bank;
            r_ready   <= n_ready;
            r_delayed <= n_delayed;
            r_cur     <= n_cur;
            r_wvld    <= n_wvld;
            r_idx     <= n_idx;
            r_chk     <= n_chk;
            r_chk_idx <= n_chk_idx;
            r_resched <= n_resched;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN))
        else $error("result strobe without finish cycle");

    a_run_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.run_valid) |-> o_result.ready_set[o_result.run_priority])
        else $error("running priority not in ready set");

    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (((o_result.ready_set | o_result.delayed_set) & ~P_MASK) == '0))
        else $error("mask bit beyond priority range");

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("wake check outside scan");
`endif

endmodule

FILE: test/priority_tick_scheduler_tb.sv
`timescale 1ns / 100ps
// Testbench for priority_tick_scheduler: directed and random create, delay, tick and
// unused-kind commands, each result checked against a local scheduler prediction.
// Depends on pts_pkg and priority_tick_scheduler.
module priority_tick_scheduler_tb;
    import pts_pkg::*;

    localparam int          NUM_PRIO    = 32;
    localparam logic [31:0] PRIO_MASK   = 32'hFFFF_FFFF >> (32 - NUM_PRIO);
    localparam t_kind       KIND_UNUSED = 2'd3;
    localparam int          RAND_ITEMS  = 1830;
    localparam int          CYCLE_LIMIT = 1000000;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // scheduler state as predicted
    logic [31:0] tick_cnt;
    logic [31:0] wake_mem [0:63];
    logic        bank;
    logic [31:0] ready_m;
    logic [31:0] delayed_m;
    logic [4:0]  cur_prio;

    t_item   pending_cmds [$];
    t_result expected_runs [$];
    int      accepted = 0;
    int      err_cnt  = 0;
    int      cycles   = 0;

    priority_tick_scheduler #(
        .NUM_PRIORITIES(NUM_PRIO)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic add_cmd(input t_kind k, input logic [15:0] dly, input logic [4:0] prio);
        t_item it;
        it.kind          = k;
        it.delay_ticks   = dly;
        it.task_priority = prio;
        pending_cmds.push_back(it);
    endtask

    function automatic void pick_highest_ready();
        if (ready_m != 0) begin
            for (int p = 31; p >= 0; p--) begin
                if (ready_m[p]) begin
                    cur_prio = 5'(p);
                    break;
                end
            end
        end
    endfunction

    function automatic t_result sched_step(input t_item it);
        t_result     r;
        logic [31:0] wake;
        int          cb;
        int          ob;
        cb = bank ? BANK_SIZE : 0;
        ob = bank ? 0 : BANK_SIZE;
        case (it.kind)
            KIND_TICK: begin
                tick_cnt = tick_cnt + 32'd1;
                if (tick_cnt == 0) begin
                    bank = ~bank;
                    cb   = bank ? BANK_SIZE : 0;
                end
                for (int i = 0; i < NUM_PRIO; i++) begin
                    if (wake_mem[cb + i] != 0 && tick_cnt >= wake_mem[cb + i]) begin
                        wake_mem[cb + i] = '0;
                        delayed_m[i]     = 1'b0;
                        ready_m[i]       = 1'b1;
                    end
                end
                ready_m   = ready_m & PRIO_MASK;
                delayed_m = delayed_m & PRIO_MASK;
                pick_highest_ready();
            end
            KIND_DELAY: begin
                wake = tick_cnt + 32'(it.delay_ticks);
                if (wake < tick_cnt) begin
                    wake_mem[ob + cur_prio] = wake;
                end else begin
                    wake_mem[cb + cur_prio] = wake;
                end
                delayed_m[cur_prio] = 1'b1;
                ready_m[cur_prio]   = 1'b0;
                delayed_m           = delayed_m & PRIO_MASK;
                pick_highest_ready();
            end
            KIND_CREATE: begin
                if (it.task_priority < NUM_PRIO) begin
                    cur_prio                  = it.task_priority;
                    ready_m[it.task_priority] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.run_priority = cur_prio;
        r.run_valid    = (ready_m != 0);
        r.ready_set    = ready_m;
        r.delayed_set  = delayed_m;
        r.tick_now     = tick_cnt;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_proc
        logic quiet;
        logic idle;
        quiet = (accepted >= 800 && accepted < 1100);
        idle  = !quiet && ($urandom_range(0, 99) < 20);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_runs.push_back(sched_step(i_item));
                accepted++;
            end
            if (start && busy) begin
                // hold until the transfer
            end else if (pending_cmds.size() > 0 && !idle) begin
                start  <= 1'b1;
                i_item <= pending_cmds.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_proc
        t_result exp_r;
        if (i_rst_n && o_done) begin
            if (expected_runs.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                exp_r = expected_runs.pop_front();
                if (o_result.run_priority !== exp_r.run_priority)
                    report_mismatch($sformatf("run_priority %0d, expected %0d",
                        o_result.run_priority, exp_r.run_priority));
                if (o_result.run_valid !== exp_r.run_valid)
                    report_mismatch($sformatf("run_valid %0b, expected %0b",
                        o_result.run_valid, exp_r.run_valid));
                if (o_result.ready_set !== exp_r.ready_set)
                    report_mismatch($sformatf("ready_set %h, expected %h",
                        o_result.ready_set, exp_r.ready_set));
                if (o_result.delayed_set !== exp_r.delayed_set)
                    report_mismatch($sformatf("delayed_set %h, expected %h",
                        o_result.delayed_set, exp_r.delayed_set));
                if (o_result.tick_now !== exp_r.tick_now)
                    report_mismatch($sformatf("tick_now %0d, expected %0d",
                        o_result.tick_now, exp_r.tick_now));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stim_proc
        int sel;
        tick_cnt  = '0;
        bank      = 1'b0;
        ready_m   = '0;
        delayed_m = '0;
        cur_prio  = '0;
        for (int i = 0; i < 64; i++) begin
            wake_mem[i] = '0;
        end

        // directed
        add_cmd(KIND_DELAY, 16'd0, 5'd0);        // nothing ready, wake time of zero
        add_cmd(KIND_TICK, 16'd0, 5'd0);         // tick with nothing ready
        add_cmd(KIND_UNUSED, 16'hFFFF, 5'd31);
        add_cmd(KIND_CREATE, 16'd0, 5'd0);       // create of a delayed task
        add_cmd(KIND_CREATE, 16'hFFFF, 5'd31);
        add_cmd(KIND_CREATE, 16'd0, 5'd5);
        add_cmd(KIND_DELAY, 16'hFFFF, 5'd0);
        add_cmd(KIND_DELAY, 16'd0, 5'd31);
        add_cmd(KIND_TICK, 16'hFFFF, 5'd31);
        add_cmd(KIND_CREATE, 16'd0, 5'd16);
        add_cmd(KIND_DELAY, 16'd2, 5'd0);
        add_cmd(KIND_TICK, 16'd0, 5'd0);
        add_cmd(KIND_TICK, 16'd0, 5'd0);
        add_cmd(KIND_TICK, 16'd0, 5'd0);
        add_cmd(KIND_DELAY, 16'd1, 5'd0);
        add_cmd(KIND_DELAY, 16'd1, 5'd0);
        add_cmd(KIND_DELAY, 16'd3, 5'd0);
        add_cmd(KIND_DELAY, 16'd4, 5'd0);
        add_cmd(KIND_TICK, 16'd0, 5'd0);
        add_cmd(KIND_TICK, 16'd0, 5'd0);
        add_cmd(KIND_UNUSED, 16'd0, 5'd0);
        add_cmd(KIND_TICK, 16'h8000, 5'd16);

        // random
        for (int n = 0; n < RAND_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                add_cmd(KIND_TICK, 16'($urandom), 5'($urandom));
            end else if (sel < 60) begin
                if ($urandom_range(0, 99) < 85)
                    add_cmd(KIND_DELAY, 16'($urandom_range(0, 12)), 5'($urandom));
                else
                    add_cmd(KIND_DELAY, 16'($urandom), 5'($urandom));
            end else if (sel < 92) begin
                add_cmd(KIND_CREATE, 16'($urandom), 5'($urandom_range(0, 31)));
            end else begin
                add_cmd(t_kind'($urandom_range(0, 3)), 16'($urandom), 5'($urandom));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start || expected_runs.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_PRIO + 10) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
